[src/lcsa_pkg.sv]
// ----------------------------------------------------------------------------
// lcsa_pkg
// Shared types and constants for the lowest-cost spot allocator: field
// widths, table sizes, command kinds, result codes and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsa_pkg;

  localparam int unsigned TICKET_W   = 8;
  localparam int unsigned LOC_W      = 6;
  localparam int unsigned COST_W     = 16;
  localparam int unsigned ALT_W      = 4;
  localparam int unsigned STATUS_W   = 2;

  // Table sizes follow from the fixed field widths
  localparam int unsigned NUM_LOCATIONS    = 1 << LOC_W;
  localparam int unsigned NUM_TICKETS      = 1 << TICKET_W;
  localparam int unsigned MAX_ALTERNATIVES = 1 << ALT_W;

  localparam logic [ALT_W-1:0] ALT_SAT = ALT_W'(MAX_ALTERNATIVES - 1);

  typedef enum logic {
    CMD_CLAIM   = 1'b0,
    CMD_RELEASE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    KIND_RELEASE     = 2'd0,
    KIND_CLAIM_FIRST = 2'd1,
    KIND_CLAIM_NEXT  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOT_HELD  = 2'd3
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [TICKET_W-1:0] ticket;
    logic [LOC_W-1:0]    location;
    logic [COST_W-1:0]   cost;
    logic                last;
    logic [ALT_W-1:0]    alt;
  } entry_t;

endpackage

`default_nettype wire

[src/lcsa_ram.sv]
// ----------------------------------------------------------------------------
// lcsa_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/lcsa_front.sv]
// ----------------------------------------------------------------------------
// lcsa_front
// Input side: tracks claim runs and tags each transaction as a release, the
// first alternative of a claim or a later one, with its saturated position.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_command_i,
  input  wire logic [lcsa_pkg::TICKET_W-1:0]   in_ticket_i,
  input  wire logic [lcsa_pkg::LOC_W-1:0]      in_location_i,
  input  wire logic [lcsa_pkg::COST_W-1:0]     in_cost_i,
  input  wire logic                            in_last_i,
  input  wire logic                            queue_ready_i,
  output logic                                 push_o,
  output lcsa_pkg::entry_t                     entry_o
);

  logic                        claim_open_q, claim_open_d;
  logic [lcsa_pkg::ALT_W-1:0]  alt_q, alt_d;
  logic                        is_release;
  logic [lcsa_pkg::ALT_W-1:0]  alt_cur;

  assign push_o     = in_valid_i && queue_ready_i;
  assign is_release = (lcsa_pkg::command_e'(in_command_i) == lcsa_pkg::CMD_RELEASE);
  assign alt_cur    = claim_open_q ? alt_q : '0;

  always_comb begin
    entry_o.ticket   = in_ticket_i;
    entry_o.location = in_location_i;
    entry_o.cost     = in_cost_i;
    entry_o.last     = in_last_i;
    entry_o.alt      = alt_cur;
    if (is_release) begin
      entry_o.kind = lcsa_pkg::KIND_RELEASE;
    end else if (claim_open_q) begin
      entry_o.kind = lcsa_pkg::KIND_CLAIM_NEXT;
    end else begin
      entry_o.kind = lcsa_pkg::KIND_CLAIM_FIRST;
    end
  end

  // Releases leave the run untouched
  always_comb begin
    claim_open_d = claim_open_q;
    alt_d        = alt_q;
    if (push_o && !is_release) begin
      if (in_last_i) begin
        claim_open_d = 1'b0;
        alt_d        = '0;
      end else begin
        claim_open_d = 1'b1;
        alt_d        = (alt_cur == lcsa_pkg::ALT_SAT) ? alt_cur : alt_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      claim_open_q <= 1'b0;
      alt_q        <= '0;
    end else begin
      claim_open_q <= claim_open_d;
      alt_q        <= alt_d;
    end
  end

endmodule

`default_nettype wire

[src/lcsa_fifo.sv]
// ----------------------------------------------------------------------------
// lcsa_fifo
// Short queue of classified transactions between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lcsa_pkg::entry_t push_entry_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output lcsa_pkg::entry_t      pop_entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcsa_pkg::entry_t   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign ready_o     = (count_q != CNT_W'(DEPTH));
  assign valid_o     = (count_q != '0);
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

[src/lcsa_back.sv]
// ----------------------------------------------------------------------------
// lcsa_back
// Execution side: reads the ticket's held location, updates the occupancy
// and holding bits, tracks the cheapest free alternative and produces the
// result into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              queue_valid_i,
  input  wire lcsa_pkg::entry_t                  queue_entry_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lcsa_pkg::status_e                      out_status_o,
  output logic [lcsa_pkg::ALT_W-1:0]             out_alt_o,
  output logic [lcsa_pkg::LOC_W-1:0]             out_spot_o
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } back_state_e;

  back_state_e                          state_q, state_d;
  lcsa_pkg::entry_t                     cur_q;

  logic [lcsa_pkg::NUM_LOCATIONS-1:0]   occupied_q, occupied_d;
  logic [lcsa_pkg::NUM_TICKETS-1:0]     holds_q, holds_d;

  logic                                 best_found_q;
  logic [lcsa_pkg::COST_W-1:0]          best_cost_q;
  logic [lcsa_pkg::ALT_W-1:0]           best_alt_q;
  logic [lcsa_pkg::LOC_W-1:0]           best_loc_q;

  logic                                 found_b, found_n;
  logic [lcsa_pkg::COST_W-1:0]          cost_b, cost_n;
  logic [lcsa_pkg::ALT_W-1:0]           alt_b, alt_n;
  logic [lcsa_pkg::LOC_W-1:0]           loc_b, loc_n;

  logic [lcsa_pkg::LOC_W-1:0]           held_loc;
  logic                                 held, free_old, loc_busy, take;
  logic                                 is_release, is_first, has_result, grant, fire;

  logic                                 out_valid_q, out_valid_d;
  lcsa_pkg::status_e                    out_status_q, res_status;
  logic [lcsa_pkg::ALT_W-1:0]           out_alt_q, res_alt;
  logic [lcsa_pkg::LOC_W-1:0]           out_spot_q, res_spot;

  lcsa_ram #(
    .WIDTH (lcsa_pkg::LOC_W),
    .DEPTH (lcsa_pkg::NUM_TICKETS)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (grant),
    .waddr_i (cur_q.ticket),
    .wdata_i (loc_n),
    .re_i    (pop_o),
    .raddr_i (queue_entry_i.ticket),
    .rdata_o (held_loc)
  );

  assign pop_o = (state_q == B_IDLE) && queue_valid_i;

  assign is_release = (cur_q.kind == lcsa_pkg::KIND_RELEASE);
  assign is_first   = (cur_q.kind == lcsa_pkg::KIND_CLAIM_FIRST);
  assign held       = holds_q[cur_q.ticket];
  assign free_old   = held && (is_release || is_first);

  // A spot freed by this same transaction counts as free
  assign loc_busy = occupied_q[cur_q.location] &&
                    !(free_old && (held_loc == cur_q.location));

  assign found_b = is_first ? 1'b0 : best_found_q;
  assign cost_b  = is_first ? '0   : best_cost_q;
  assign alt_b   = is_first ? '0   : best_alt_q;
  assign loc_b   = is_first ? '0   : best_loc_q;

  assign take    = !loc_busy && (!found_b || (cur_q.cost < cost_b));
  assign found_n = take ? 1'b1        : found_b;
  assign cost_n  = take ? cur_q.cost  : cost_b;
  assign alt_n   = take ? cur_q.alt   : alt_b;
  assign loc_n   = take ? cur_q.location : loc_b;

  assign has_result = is_release || cur_q.last;
  assign fire       = (state_q == B_EXEC) && (!has_result || !out_valid_q || out_ready_i);
  assign grant      = fire && !is_release && cur_q.last && found_n;

  always_comb begin
    res_status = lcsa_pkg::ST_NONE_FREE;
    res_alt    = '0;
    res_spot   = '0;
    if (is_release) begin
      if (held) begin
        res_status = lcsa_pkg::ST_RELEASED;
        res_spot   = held_loc;
      end else begin
        res_status = lcsa_pkg::ST_NOT_HELD;
      end
    end else if (found_n) begin
      res_status = lcsa_pkg::ST_GRANTED;
      res_alt    = alt_n;
      res_spot   = loc_n;
    end
  end

  always_comb begin
    occupied_d = occupied_q;
    holds_d    = holds_q;
    if (fire && free_old) begin
      occupied_d[held_loc]   = 1'b0;
      holds_d[cur_q.ticket]  = 1'b0;
    end
    // Grant after the free so a re-granted spot stays taken
    if (grant) begin
      occupied_d[loc_n]      = 1'b1;
      holds_d[cur_q.ticket]  = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (queue_valid_i) state_d = B_EXEC;
      B_EXEC: if (fire) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (fire && has_result);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      occupied_q   <= '0;
      holds_q      <= '0;
      best_found_q <= 1'b0;
      best_cost_q  <= '0;
      best_alt_q   <= '0;
      best_loc_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      occupied_q  <= occupied_d;
      holds_q     <= holds_d;
      out_valid_q <= out_valid_d;
      if (fire && !is_release) begin
        best_found_q <= cur_q.last ? 1'b0 : found_n;
        best_cost_q  <= cost_n;
        best_alt_q   <= alt_n;
        best_loc_q   <= loc_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= queue_entry_i;
    end
    if (fire && has_result) begin
      out_status_q <= res_status;
      out_alt_q    <= res_alt;
      out_spot_q   <= res_spot;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_alt_o    = out_alt_q;
  assign out_spot_o   = out_spot_q;

  a_grant_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grant |=> occupied_q[$past(loc_n)] && holds_q[$past(cur_q.ticket)])
    else $error("granted spot not recorded");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_release) |=> !holds_q[$past(cur_q.ticket)])
    else $error("released ticket still holds a spot");

  a_held_le_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(holds_q) <= $countones(occupied_q))
    else $error("more holding tickets than occupied spots");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(fire && has_result))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[src/lowest_cost_spot_allocator.sv]
// ----------------------------------------------------------------------------
// lowest_cost_spot_allocator
// Reservation table for 64 locations and 256 tickets: claims pick the
// cheapest free alternative, releases free a ticket's spot.
// ----------------------------------------------------------------------------
// The execution part handles one transaction at a time: it first reads
// the ticket's stored location from the holding RAM, then updates the
// occupancy and holding bits and the best-candidate registers; a step that
// gives a result waits while the last one is not yet taken. The input
// side takes transactions into a queue of QUEUE_DEPTH entries while a
// result waits in the output register. Claim alternatives give no result
// until the one marked tlast; every release gives one. Reset clears all
// occupancy and holding bits at once, so no clearing pass is needed.
`default_nettype none

module lowest_cost_spot_allocator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // ticket[7:0], location[13:8], cost[29:14], zero
  input  wire logic        s_axis_tuser,  // command
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // alternative[3:0], spot[9:4], zero
  output logic [1:0]       m_axis_tuser   // status
);

  lcsa_pkg::entry_t   push_entry, pop_entry;
  logic               push, queue_ready, queue_valid, pop;
  lcsa_pkg::status_e  out_status;
  logic [lcsa_pkg::ALT_W-1:0] out_alt;
  logic [lcsa_pkg::LOC_W-1:0] out_spot;

  lcsa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_command_i  (s_axis_tuser),
    .in_ticket_i   (s_axis_tdata[7:0]),
    .in_location_i (s_axis_tdata[13:8]),
    .in_cost_i     (s_axis_tdata[29:14]),
    .in_last_i     (s_axis_tlast),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  lcsa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (queue_ready),
    .valid_o      (queue_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  lcsa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .queue_entry_i (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (out_status),
    .out_alt_o     (out_alt),
    .out_spot_o    (out_spot)
  );

  assign s_axis_tready = queue_ready;
  assign m_axis_tdata  = {6'b0, out_spot, out_alt};
  assign m_axis_tuser  = out_status;

endmodule

`default_nettype wire
